@@ rtl/symmetric_int8_quantizer_top_macros.svh @@
// Assertion macros for the symmetric int8 quantizer.
// Included by symmetric_int8_quantizer_top.sv; expects clk and rst_n in scope.
`ifndef SYMMETRIC_INT8_QUANTIZER_TOP_MACROS_SVH
`define SYMMETRIC_INT8_QUANTIZER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SIQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("siq assertion failed");
`define SIQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("siq assertion failed");
`else
`define SIQ_ASSERT_NOW(label, ante, cons)
`define SIQ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/siq_pkg.sv @@
// Shared types and constants for the symmetric int8 quantizer.
// No dependencies; used by siq_div and the top level.
`timescale 1ns / 1ps
package siq_pkg;

  localparam int SAMPLE_W  = 32;
  localparam int Q_W       = 8;
  localparam int QMAG_W    = 7;
  localparam int DIV_STEPS = 8;   // quotient never exceeds 8 bits
  localparam int NUM_W     = 40;  // holds 255 * 2^31 and (2 * 2^31) << 7

  localparam logic [QMAG_W-1:0] QMAX = 7'd127;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_MAG  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  typedef struct packed {
    logic                go;
    logic [SAMPLE_W-1:0] mag;
    logic [SAMPLE_W-1:0] maxv;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QMAG_W-1:0] quo;
  } div_rsp_t;

endpackage

@@ rtl/siq_div.sv @@
// Shared restoring divider: |q| = floor((254*mag + max) / (2*max)), clamped to 127.
// One quotient bit per cycle after a load cycle. Depends on siq_pkg.
`timescale 1ns / 1ps
module siq_div
  import siq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(DIV_STEPS - 1);

  logic             run_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] rem_r;
  logic [NUM_W-1:0] den_r;
  logic [Q_W-1:0]   quo_r;
  logic             zero_r;

  logic [NUM_W-1:0] mag_ext;
  logic [NUM_W-1:0] max_ext;
  logic [NUM_W-1:0] num;
  logic             fits;

  // 254*mag = (mag << 8) - (mag << 1)
  assign mag_ext = NUM_W'(req.mag);
  assign max_ext = NUM_W'(req.maxv);
  assign num     = (mag_ext << 8) - (mag_ext << 1) + max_ext;
  assign fits    = rem_r >= den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == STEP_LAST) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      rem_r  <= num;
      den_r  <= max_ext << (DIV_STEPS);  // (2*max) << (steps-1)
      quo_r  <= '0;
      zero_r <= (req.maxv == '0);
    end else if (run_r) begin
      if (fits) begin
        rem_r <= rem_r - den_r;
      end
      quo_r <= {quo_r[Q_W-2:0], fits};
      den_r <= den_r >> 1;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = zero_r ? '0 : (quo_r[Q_W-1] ? QMAX : quo_r[QMAG_W-1:0]);

endmodule

@@ rtl/symmetric_int8_quantizer_top.sv @@
// Symmetric int8 per-tensor quantizer, top level.
// Depends on siq_pkg, siq_div and symmetric_int8_quantizer_top_macros.svh.
//
// Input: an item (in_sample, Q16.16 signed, and in_end_of_burst) is taken at a
// rising edge where start is high and busy is low. Items of a burst are stored
// one per cycle while the block tracks the largest magnitude.
// An item with in_end_of_burst set closes the burst; an item that arrives with
// the store full is dropped and closes the burst as well.
// Output: after a burst closes, one item per stored sample leaves in arrival
// order, each shown for one cycle with out_valid high. out_quantized is
// round(v*127/max), half away from zero; out_max_magnitude carries max and
// out_final_result marks the last item of the burst.
// Sequencing: each output item passes through a store read, a magnitude
// state that loads the shared divider, one quotient bit per cycle, a wait for
// the divider's done flag, then the output register. busy stays high while a
// burst drains. The receiver cannot stall: out_valid is a one-cycle strobe.
// Reset clears the fill count, running maximum and sequencer; the sample
// store is not cleared since only written entries are read.
`timescale 1ns / 1ps
`include "symmetric_int8_quantizer_top_macros.svh"
module symmetric_int8_quantizer_top
  import siq_pkg::*;
#(
  parameter int BURST_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic                in_end_of_burst,
  output logic                out_valid,
  output logic [Q_W-1:0]      out_quantized,
  output logic [SAMPLE_W-1:0] out_max_magnitude,
  output logic                out_final_result
);

  localparam int AW = (BURST_DEPTH > 1) ? $clog2(BURST_DEPTH) : 1;
  localparam int FW = $clog2(BURST_DEPTH + 1);
  localparam logic [FW-1:0] FULL = FW'(BURST_DEPTH);

  state_t              state_r, state_nxt;
  logic [FW-1:0]       fill_r, fill_nxt;
  logic [SAMPLE_W-1:0] max_r, max_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_final_r, out_final_nxt;
  logic [Q_W-1:0]      out_q_r;
  logic [SAMPLE_W-1:0] out_max_r;
  logic                neg_r;

  logic [SAMPLE_W-1:0] mem [BURST_DEPTH];
  logic [SAMPLE_W-1:0] rd_data_r;

  logic                accept;
  logic                full;
  logic                do_store;
  logic [SAMPLE_W-1:0] in_mag;
  logic [SAMPLE_W-1:0] rd_mag;
  logic                last_idx;
  logic [Q_W-1:0]      q_mag;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  assign accept   = start && !busy;
  assign full     = (fill_r == FULL);
  assign do_store = accept && !full;
  assign in_mag   = in_sample[SAMPLE_W-1] ? (~in_sample + SAMPLE_W'(1)) : in_sample;
  assign rd_mag   = rd_data_r[SAMPLE_W-1] ? (~rd_data_r + SAMPLE_W'(1)) : rd_data_r;
  assign last_idx = ((FW'(idx_r) + FW'(1)) == fill_r);
  assign q_mag    = {1'b0, div_rsp.quo};

  assign div_req.go   = (state_r == ST_MAG);
  assign div_req.mag  = rd_mag;
  assign div_req.maxv = max_r;

  siq_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // sample store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (do_store) begin
      mem[fill_r[AW-1:0]] <= in_sample;
    end
    rd_data_r <= mem[idx_r];
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    max_nxt       = max_r;
    idx_nxt       = idx_r;
    out_valid_nxt = 1'b0;
    out_final_nxt = out_final_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          idx_nxt = '0;
          if (full) begin
            state_nxt = ST_READ;
          end else begin
            fill_nxt = fill_r + FW'(1);
            if (in_mag > max_r) begin
              max_nxt = in_mag;
            end
            if (in_end_of_burst) begin
              state_nxt = ST_READ;
            end
          end
        end
      end
      ST_READ: state_nxt = ST_MAG;
      ST_MAG:  state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid_nxt = 1'b1;
        out_final_nxt = last_idx;
        if (last_idx) begin
          state_nxt = ST_IDLE;
          fill_nxt  = '0;
          max_nxt   = '0;
        end else begin
          state_nxt = ST_READ;
          idx_nxt   = idx_r + AW'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      max_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      out_final_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      max_r       <= max_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      out_final_r <= out_final_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_MAG) begin
      neg_r <= rd_data_r[SAMPLE_W-1];
    end
    if (state_r == ST_OUT) begin
      out_q_r   <= neg_r ? (~q_mag + Q_W'(1)) : q_mag;
      out_max_r <= max_r;
    end
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_quantized     = out_q_r;
  assign out_max_magnitude = out_max_r;
  assign out_final_result  = out_final_r;

  `SIQ_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= FULL)
  `SIQ_ASSERT_NOW(a_final_clears, out_valid_r && out_final_r, state_r == ST_IDLE && fill_r == '0 && max_r == '0)
  `SIQ_ASSERT_NOW(a_more_follows, out_valid_r && !out_final_r, state_r == ST_READ)
  `SIQ_ASSERT_NOW(a_zero_max, out_valid_r && out_max_r == '0, out_q_r == '0)
  `SIQ_ASSERT_NEXT(a_div_done, state_r == ST_DIV && div_rsp.done, state_r == ST_OUT)

endmodule
